FILE: rtl/core/swcs_pkg.sv
// shared constants and types for the sliding window congestion sender
// no dependencies
package swcs_pkg;
  localparam int SeqSpaceDef   = 32768;
  localparam int QueueDepthDef = 32;
  localparam int CwndW = 22;
  localparam int MssW  = 11;
  localparam int WinW  = 14;
  localparam int TickW = 16;
  localparam int SeqW  = 15;
  localparam int CntW  = 6;
  localparam int ClsW  = 3;
  localparam int CfgIdxW = 3;

  localparam logic [1:0] OpSend = 2'd0;
  localparam logic [1:0] OpAck  = 2'd1;
  localparam logic [1:0] OpTick = 2'd2;

  localparam logic [ClsW-1:0] ClsNone    = 3'd0;
  localparam logic [ClsW-1:0] ClsOldest  = 3'd1;
  localparam logic [ClsW-1:0] ClsDup     = 3'd2;
  localparam logic [ClsW-1:0] ClsMatched = 3'd3;
  localparam logic [ClsW-1:0] ClsFlushed = 3'd4;
  localparam logic [ClsW-1:0] ClsEmpty   = 3'd5;

  localparam logic [CfgIdxW-1:0] RegMss      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCap      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegThrInit  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegThrFloor = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTimeout  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStartSeq = 3'd5;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [MssW-1:0]   mss;
    logic [CwndW-1:0]  cwnd;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [37:0]       quot;
  } div_rsp_t;
endpackage

FILE: rtl/core/swcs_div.sv
// serial restoring divider: (mss*mss << 16) / cwnd, one quotient bit per cycle
// depends on swcs_pkg
module swcs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swcs_pkg::div_req_t  req_i,
  output swcs_pkg::div_rsp_t  rsp_o
);
  import swcs_pkg::*;

  localparam int NumW = 38;

  logic [NumW-1:0]  num_q, num_d;
  logic [CwndW:0]   rem_q, rem_d;
  logic [CwndW-1:0] den_q, den_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [21:0]      sq;
  logic [CwndW:0]   shifted, diff;

  assign sq = 22'(req_i.mss) * 22'(req_i.mss);
  assign shifted = {rem_q[CwndW-1:0], num_q[NumW-1]};
  assign diff = shifted - {1'b0, den_q};

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d = {sq, 16'd0};
      rem_d = '0;
      den_d = req_i.cwnd;
      cnt_d = 6'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[CwndW]) begin
        rem_d = diff;
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o = {done_q, num_q};
endmodule

FILE: rtl/core/swcs_queue.sv
// segment queue memory: one write port, one registered read port
// depends on swcs_pkg
module swcs_queue #(
  parameter int QueueDepth = swcs_pkg::QueueDepthDef,
  parameter int SeqSpace   = swcs_pkg::SeqSpaceDef
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(QueueDepth)-1:0] waddr_i,
  input  logic [$clog2(SeqSpace)-1:0]   wstart_i,
  input  logic [swcs_pkg::MssW-1:0]     wlen_i,
  input  logic [$clog2(QueueDepth)-1:0] raddr_i,
  output logic [$clog2(SeqSpace)-1:0]   rstart_o,
  output logic [swcs_pkg::MssW-1:0]     rlen_o
);
  import swcs_pkg::*;

  localparam int SW = $clog2(SeqSpace);

  logic [SW+MssW-1:0] mem [QueueDepth];
  logic [SW+MssW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= {wstart_i, wlen_i};
    rd_q <= mem[raddr_i];
  end

  assign rstart_o = rd_q[SW+MssW-1:MssW];
  assign rlen_o = rd_q[MssW-1:0];
endmodule

FILE: rtl/core/sliding_window_congestion_sender.sv
// sliding window congestion sender top level: control sequencer and state
// depends on swcs_pkg, swcs_queue, swcs_div
//
// usage: pulse start with opcode_i, segment_length_i and ack_number_i while
// busy is low. exactly one result follows, shown for one cycle with
// valid_o high; the receiver cannot stall it.
// opcodes: segment sent, ack received, timer tick.
// latency (busy states after the accepting edge): send StSend, StOut; tick
// StTickRd (one queue memory read), StTick, StOut; unknown opcode, or ack or
// tick on an empty queue StOut; duplicate ack StAckRd, StAckCmp, StOut; ack of
// the oldest segment adds StGrow; a newer ack pops in StPopCmp/StPopRd, StGrow
// on a match; avoidance growth adds StDivWait (one-bit-per-cycle 38-bit divider).
// throughput: the result shows in the first cycle with busy low and the next
// transaction may be taken in that same cycle, so items are latency+1 apart.
// configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i,
// taken only while idle. writing start_seq empties the queue.
// reset: this module's registers take their reset values; the queue memory needs no
// clearing because entries are only read after being written.
module sliding_window_congestion_sender #(
  parameter int SeqSpace   = swcs_pkg::SeqSpaceDef,
  parameter int QueueDepth = swcs_pkg::QueueDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        opcode_i,
  input  logic [swcs_pkg::MssW-1:0]         segment_length_i,
  input  logic [swcs_pkg::SeqW-1:0]         ack_number_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [swcs_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [15:0]                       cfg_data_i,
  output logic                              valid_o,
  output logic [swcs_pkg::ClsW-1:0]         ack_class_o,
  output logic                              retransmit_o,
  output logic [swcs_pkg::SeqW-1:0]         retransmit_seq_o,
  output logic [swcs_pkg::MssW-1:0]         retransmit_length_o,
  output logic [swcs_pkg::WinW-1:0]         window_bytes_o,
  output logic [swcs_pkg::WinW-1:0]         threshold_bytes_o,
  output logic                              send_allowed_o,
  output logic [swcs_pkg::SeqW-1:0]         next_sequence_o,
  output logic [swcs_pkg::CntW-1:0]         outstanding_o,
  output logic                              overflow_o
);
  import swcs_pkg::*;

  localparam int SW = $clog2(SeqSpace);
  localparam int QW = $clog2(QueueDepth);
  localparam int CW = $clog2(QueueDepth + 1);
  localparam logic [CW-1:0] Full = CW'(QueueDepth);
  localparam logic [SW:0] Half = (SW+1)'(SeqSpace / 2);

  typedef enum logic [3:0] {
    StIdle, StSend, StTickRd, StTick, StAckRd, StAckCmp, StPopRd, StPopCmp,
    StGrow, StDivWait, StOut
  } state_e;

  state_e state_q;
  logic [MssW-1:0]  mss_q;
  logic [WinW-1:0]  cap_q, thr_floor_q;
  logic [TickW-1:0] timeout_q;
  logic [QW-1:0]    head_q;
  logic [CW-1:0]    count_q;
  logic [CwndW-1:0] cwnd_q;
  logic [WinW-1:0]  ssthr_q;
  logic [SW-1:0]    base_q, next_q, ack_q;
  logic [TickW-1:0] tick_q;
  logic [MssW-1:0]  len_q;
  logic [ClsW-1:0]  cls_q;
  logic             rtx_q, ovf_q, valid_q;
  logic [SeqW-1:0]  rtx_seq_q;
  logic [MssW-1:0]  rtx_len_q;

  logic          q_we;
  logic [QW-1:0] q_waddr;
  logic [SW-1:0] rd_start;
  logic [MssW-1:0] rd_len;
  div_req_t      dreq;
  div_rsp_t      drsp;

  swcs_queue #(.QueueDepth(QueueDepth), .SeqSpace(SeqSpace)) u_queue (
    .clk_i    (clk_i),
    .we_i     (q_we),
    .waddr_i  (q_waddr),
    .wstart_i (next_q),
    .wlen_i   (len_q),
    .raddr_i  (head_q),
    .rstart_o (rd_start),
    .rlen_o   (rd_len)
  );

  swcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  function automatic logic seq_before(logic [SW-1:0] a, logic [SW-1:0] b);
    logic [SW:0] d, mag;
    d = {1'b0, b} - {1'b0, a};
    mag = d[SW] ? ((SW+1)'(0) - d) : d;
    if (mag > Half) seq_before = d[SW];
    else seq_before = !d[SW] && (d != '0);
  endfunction

  logic [SW-1:0] head_end;
  logic          accept;
  logic [CW-1:0] tail_sum;
  logic [TickW-1:0] tick_inc;
  logic [WinW-1:0]  half_w;
  logic [CwndW:0]   grow_sum;
  logic [CwndW:0]   cap_fx;
  logic [38:0]      div_sum;
  logic [SW-1:0]    target;
  logic             div_go;

  assign head_end = SW'({1'b0, rd_start} + {{(SW+1-MssW){1'b0}}, rd_len});
  assign accept = start && !busy;
  assign busy = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle) && !start;
  assign tail_sum = CW'(head_q) + count_q;
  assign q_waddr = tail_sum[QW-1:0];
  assign q_we = (state_q == StSend) && (count_q != Full);
  assign tick_inc = (tick_q == '1) ? tick_q : tick_q + 16'd1;
  assign half_w = {1'b0, cwnd_q[CwndW-1:9]};
  assign cap_fx = {1'b0, cap_q, 8'd0};
  assign grow_sum = {1'b0, cwnd_q} + {4'd0, mss_q, 8'd0};
  assign div_sum = {17'd0, cwnd_q} + {1'b0, drsp.quot};
  assign div_go = (state_q == StGrow) && (cwnd_q[CwndW-1:8] >= ssthr_q)
                  && (cwnd_q != '0);
  assign dreq = {div_go, mss_q, cwnd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mss_q <= 11'd1024;
      cap_q <= 14'd10240;
      thr_floor_q <= 14'd1024;
      timeout_q <= 16'd500;
      head_q <= '0;
      count_q <= '0;
      cwnd_q <= 22'(11'd1024) << 8;
      ssthr_q <= 14'd10240;
      base_q <= '0;
      next_q <= '0;
      tick_q <= '0;
      valid_q <= 1'b0;
      len_q <= '0;
      ack_q <= '0;
      cls_q <= ClsNone;
      rtx_q <= 1'b0;
      ovf_q <= 1'b0;
      rtx_seq_q <= '0;
      rtx_len_q <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (cfg_valid_i && cfg_ready_o) begin
            case (cfg_index_i)
              RegMss:      mss_q <= cfg_data_i[MssW-1:0];
              RegCap:      cap_q <= cfg_data_i[WinW-1:0];
              RegThrInit:  ssthr_q <= cfg_data_i[WinW-1:0];
              RegThrFloor: thr_floor_q <= cfg_data_i[WinW-1:0];
              RegTimeout:  timeout_q <= cfg_data_i;
              RegStartSeq: begin
                base_q <= SW'(cfg_data_i[SeqW-1:0]);
                next_q <= SW'(cfg_data_i[SeqW-1:0]);
                head_q <= '0;
                count_q <= '0;
                tick_q <= '0;
              end
              default: ;
            endcase
          end
          if (accept) begin
            len_q <= segment_length_i;
            ack_q <= SW'(ack_number_i);
            cls_q <= ClsNone;
            rtx_q <= 1'b0;
            ovf_q <= 1'b0;
            rtx_seq_q <= '0;
            rtx_len_q <= '0;
            case (opcode_i)
              OpSend:  state_q <= StSend;
              OpAck:   state_q <= (count_q == '0) ? StOut : StAckRd;
              OpTick:  state_q <= (count_q == '0) ? StOut : StTickRd;
              default: state_q <= StOut;
            endcase
            if (opcode_i == OpAck && count_q == '0) cls_q <= ClsEmpty;
          end
        end
        StSend: begin
          if (count_q == Full) begin
            ovf_q <= 1'b1;
          end else begin
            if (count_q == '0) tick_q <= '0;
            count_q <= count_q + CW'(1);
            next_q <= SW'({1'b0, next_q} + {{(SW+1-MssW){1'b0}}, len_q});
          end
          state_q <= StOut;
        end
        StTickRd: state_q <= StTick;
        StTick: begin
          if (tick_inc >= timeout_q) begin
            ssthr_q <= (half_w > thr_floor_q) ? half_w : thr_floor_q;
            cwnd_q <= {3'd0, mss_q, 8'd0};
            tick_q <= '0;
            rtx_q <= 1'b1;
            rtx_seq_q <= SeqW'(rd_start);
            rtx_len_q <= rd_len;
          end else begin
            tick_q <= tick_inc;
          end
          state_q <= StOut;
        end
        StAckRd: state_q <= StAckCmp;
        StAckCmp: begin
          if (ack_q == head_end) begin
            head_q <= head_q + QW'(1);
            count_q <= count_q - CW'(1);
            cls_q <= ClsOldest;
            state_q <= StGrow;
          end else if (seq_before(ack_q, head_end)) begin
            cls_q <= ClsDup;
            state_q <= StOut;
          end else begin
            cls_q <= ClsFlushed;
            state_q <= StPopCmp;
          end
        end
        StPopRd: state_q <= StPopCmp;
        StPopCmp: begin
          // head data already read for this entry
          head_q <= head_q + QW'(1);
          count_q <= count_q - CW'(1);
          if (ack_q == head_end) begin
            cls_q <= ClsMatched;
            state_q <= StGrow;
          end else if (count_q == CW'(1)) begin
            state_q <= StOut;
          end else begin
            state_q <= StPopRd;
          end
        end
        StGrow: begin
          base_q <= ack_q;
          tick_q <= '0;
          if (cwnd_q[CwndW-1:8] < ssthr_q) begin
            cwnd_q <= (grow_sum > cap_fx) ? cap_fx[CwndW-1:0] : grow_sum[CwndW-1:0];
            state_q <= StOut;
          end else if (cwnd_q == '0) begin
            cwnd_q <= cap_fx[CwndW-1:0];
            state_q <= StOut;
          end else begin
            state_q <= StDivWait;
          end
        end
        StDivWait: begin
          if (drsp.done) begin
            cwnd_q <= (div_sum > 39'(cap_fx)) ? cap_fx[CwndW-1:0] : div_sum[CwndW-1:0];
            state_q <= StOut;
          end
        end
        StOut: begin
          valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign target = SW'({1'b0, base_q} + (SW+1)'(cwnd_q[CwndW-1:8]));

  assign valid_o = valid_q;
  assign ack_class_o = cls_q;
  assign retransmit_o = rtx_q;
  assign retransmit_seq_o = rtx_seq_q;
  assign retransmit_length_o = rtx_len_q;
  assign window_bytes_o = cwnd_q[CwndW-1:8];
  assign threshold_bytes_o = ssthr_q;
  assign send_allowed_o = seq_before(next_q, target);
  assign next_sequence_o = SeqW'(next_q);
  assign outstanding_o = CntW'(count_q);
  assign overflow_o = ovf_q;
endmodule
